[hdl/reset_request_handshake_core_macros.svh]
// Assertion helpers for the reset request handshake block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef RESET_REQUEST_HANDSHAKE_CORE_MACROS_SVH
`define RESET_REQUEST_HANDSHAKE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrh assertion failed");

// Next-cycle implication, checked outside reset.
`define RRH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrh assertion failed");

`endif

[hdl/rrh_pkg.sv]
`default_nettype none
package rrh_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL       = 2'd0,
    MODE_WAIT_CONFIRM = 2'd1,
    MODE_RESET_WAIT   = 2'd2,
    MODE_RESET_EXEC   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_CONTROL    = 2'd0,
    OP_REPLY_SENT = 2'd1,
    OP_TICK       = 2'd2,
    OP_BUTTON     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_PING       = 3'd0,
    ACT_REQUEST    = 3'd1,
    ACT_CONFIRM    = 3'd2,
    ACT_DISCONNECT = 3'd3
  } act_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_ARG   = 2'd1;
  localparam logic [1:0] STATUS_BAD_STATE = 2'd2;

  localparam logic [1:0] INTENT_NONE    = 2'd0;
  localparam logic [1:0] INTENT_LOCAL   = 2'd1;
  localparam logic [1:0] INTENT_CONFIRM = 2'd2;

  localparam logic [1:0] CFG_CONFIRM_TOKEN = 2'd0;
  localparam logic [1:0] CFG_WINDOW_MS     = 2'd1;
  localparam logic [1:0] CFG_HOLD_MS       = 2'd2;

  localparam logic [31:0] TOKEN_RESET  = 32'd0;
  localparam logic [31:0] WINDOW_RESET = 32'd30000;
  localparam logic [31:0] HOLD_RESET   = 32'd1500;

  typedef struct packed {
    logic [31:0] confirm_token;
    logic [31:0] confirm_window_ms;
    logic [31:0] reply_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  action;
    logic [31:0] token;
    logic [31:0] sequence_number;
    logic [31:0] now_ms;
    logic        link_drained;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fire_reset;
    logic [1:0] boot_intent;
    logic       reset_pending;
    logic [1:0] mode_now;
  } result_t;

endpackage
`default_nettype wire

[hdl/rrh_cfg_regs.sv]
`default_nettype none
module rrh_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [1:0]    wr_index,
  input  wire logic [31:0]   wr_data,
  output rrh_pkg::cfg_t      cfg
);

  rrh_pkg::cfg_t cfg_r;
  rrh_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        rrh_pkg::CFG_CONFIRM_TOKEN: cfg_nxt.confirm_token     = wr_data;
        rrh_pkg::CFG_WINDOW_MS:     cfg_nxt.confirm_window_ms = wr_data;
        rrh_pkg::CFG_HOLD_MS:       cfg_nxt.reply_hold_ms     = wr_data;
        default: ;  // unmapped index: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.confirm_token     <= rrh_pkg::TOKEN_RESET;
      cfg_r.confirm_window_ms <= rrh_pkg::WINDOW_RESET;
      cfg_r.reply_hold_ms     <= rrh_pkg::HOLD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[hdl/rrh_engine.sv]
`default_nettype none
module rrh_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  rrh_pkg::item_t     item,
  input  rrh_pkg::cfg_t      cfg,
  output rrh_pkg::result_t   result
);

  rrh_pkg::mode_t mode_r, mode_nxt;
  logic [31:0]    request_time_r, request_time_nxt;
  logic [31:0]    expected_seq_r, expected_seq_nxt;
  logic           reply_done_r, reply_done_nxt;
  logic [31:0]    reply_time_r, reply_time_nxt;
  logic           local_origin_r, local_origin_nxt;

  logic        act_valid;
  logic [31:0] need_token;
  logic        token_ok;
  logic        pending;
  logic [31:0] since_request;
  logic [31:0] since_reply;
  logic        confirm_ok;
  logic        reply_hit;
  logic        fire_ok;

  assign act_valid  = (item.action[2] == 1'b0);
  assign need_token = (item.action == rrh_pkg::ACT_REQUEST ||
                       item.action == rrh_pkg::ACT_CONFIRM) ? cfg.confirm_token : 32'd0;
  assign token_ok   = act_valid && (item.token == need_token);
  assign pending    = (mode_r == rrh_pkg::MODE_RESET_WAIT) ||
                      (mode_r == rrh_pkg::MODE_RESET_EXEC);

  // wrapping millisecond differences
  assign since_request = item.now_ms - request_time_r;
  assign since_reply   = item.now_ms - reply_time_r;

  assign confirm_ok = (mode_r == rrh_pkg::MODE_WAIT_CONFIRM) &&
                      (since_request <= cfg.confirm_window_ms);
  assign reply_hit  = (mode_r == rrh_pkg::MODE_RESET_WAIT) &&
                      (item.sequence_number == expected_seq_r);
  assign fire_ok    = item.link_drained && reply_done_r &&
                      (since_reply >= cfg.reply_hold_ms) &&
                      (mode_r == rrh_pkg::MODE_RESET_WAIT);

  // next state
  always_comb begin
    mode_nxt         = mode_r;
    request_time_nxt = request_time_r;
    expected_seq_nxt = expected_seq_r;
    reply_done_nxt   = reply_done_r;
    reply_time_nxt   = reply_time_r;
    local_origin_nxt = local_origin_r;
    unique case (item.opcode)
      rrh_pkg::OP_CONTROL: begin
        if (token_ok) begin
          unique case (item.action)
            rrh_pkg::ACT_DISCONNECT: begin
              if (!local_origin_r && mode_r != rrh_pkg::MODE_RESET_EXEC) begin
                mode_nxt       = rrh_pkg::MODE_NORMAL;
                reply_done_nxt = 1'b0;
              end
            end
            rrh_pkg::ACT_REQUEST: begin
              if (!pending) begin
                request_time_nxt = item.now_ms;
                mode_nxt         = rrh_pkg::MODE_WAIT_CONFIRM;
              end
            end
            rrh_pkg::ACT_CONFIRM: begin
              if (confirm_ok) begin
                expected_seq_nxt = item.sequence_number;
                reply_done_nxt   = 1'b0;
                mode_nxt         = rrh_pkg::MODE_RESET_WAIT;
              end
            end
            default: ;  // ping: no state change
          endcase
        end
      end
      rrh_pkg::OP_REPLY_SENT: begin
        if (reply_hit) begin
          reply_time_nxt = item.now_ms;
          reply_done_nxt = 1'b1;
        end
      end
      rrh_pkg::OP_TICK: begin
        if (fire_ok) begin
          mode_nxt = rrh_pkg::MODE_RESET_EXEC;
        end
      end
      rrh_pkg::OP_BUTTON: begin
        if (!local_origin_r) begin
          local_origin_nxt = 1'b1;
          reply_time_nxt   = item.now_ms;
          reply_done_nxt   = 1'b1;
          mode_nxt         = rrh_pkg::MODE_RESET_WAIT;
        end
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    result.status      = rrh_pkg::STATUS_OK;
    result.fire_reset  = 1'b0;
    result.boot_intent = rrh_pkg::INTENT_NONE;
    if (item.opcode == rrh_pkg::OP_CONTROL) begin
      if (!token_ok) begin
        result.status = rrh_pkg::STATUS_BAD_ARG;
      end else if (item.action == rrh_pkg::ACT_REQUEST && pending) begin
        result.status = rrh_pkg::STATUS_BAD_STATE;
      end else if (item.action == rrh_pkg::ACT_CONFIRM && !confirm_ok) begin
        result.status = rrh_pkg::STATUS_BAD_STATE;
      end
    end else if (item.opcode == rrh_pkg::OP_TICK && fire_ok) begin
      result.fire_reset  = 1'b1;
      result.boot_intent = local_origin_r ? rrh_pkg::INTENT_LOCAL : rrh_pkg::INTENT_CONFIRM;
    end
    result.mode_now      = mode_nxt;
    result.reset_pending = (mode_nxt == rrh_pkg::MODE_RESET_WAIT) ||
                           (mode_nxt == rrh_pkg::MODE_RESET_EXEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= rrh_pkg::MODE_NORMAL;
      request_time_r <= 32'd0;
      expected_seq_r <= 32'd0;
      reply_done_r   <= 1'b0;
      reply_time_r   <= 32'd0;
      local_origin_r <= 1'b0;
    end else if (go) begin
      mode_r         <= mode_nxt;
      request_time_r <= request_time_nxt;
      expected_seq_r <= expected_seq_nxt;
      reply_done_r   <= reply_done_nxt;
      reply_time_r   <= reply_time_nxt;
      local_origin_r <= local_origin_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/reset_request_handshake_core.sv]
// Reset request handshake core.
// Input channel (in_*): one event per transfer: control action, reply sent,
// process tick or local button. Transfer happens when in_valid is high and
// in_stall is low.
// Result channel (out_*): exactly one result per input event, in order, with
// status, fire_reset, boot_intent, reset_pending and the mode after the event.
// The receiver holds out_stall high to keep the current result on the port.
// Config channel (cfg_*): index 0 confirm token, 1 confirm window in ms,
// 2 reply hold time in ms; always ready. Write only while no event is in flight.
// A result passes the input register, then the result register, before it is
// on the out_ ports, and transfers when out_stall is low.
// Throughput: one event per cycle while out_stall is low; the event logic reads
// the handshake state and updates it in the same cycle the result is registered.
// A stalled result stops the result register; one more event is held in the
// input register, then in_stall rises until the result is taken.
// Synchronous reset (rst_n low) returns the mode to normal, clears all stamps
// and loads the config defaults (token 0, window 30000, hold 1500).
`default_nettype none
module reset_request_handshake_core (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_token,
  input  wire logic [31:0] in_sequence_number,
  input  wire logic [31:0] in_now_ms,
  input  wire logic        in_link_drained,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_fire_reset,
  output logic [1:0]       out_boot_intent,
  output logic             out_reset_pending,
  output logic [1:0]       out_mode_now,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  rrh_pkg::cfg_t    cfg;
  rrh_pkg::item_t   item_r;
  rrh_pkg::result_t result;
  rrh_pkg::result_t result_r;

  logic in_valid_r, in_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_take;
  logic advance;
  logic go;

  assign cfg_ready = 1'b1;

  rrh_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // the result register frees up when empty or when its transfer completes
  assign advance  = !out_valid_r || !out_stall;
  assign go       = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (go) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode          <= in_opcode;
      item_r.action          <= in_action;
      item_r.token           <= in_token;
      item_r.sequence_number <= in_sequence_number;
      item_r.now_ms          <= in_now_ms;
      item_r.link_drained    <= in_link_drained;
    end
    if (go) begin
      result_r <= result;
    end
  end

  rrh_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = result_r.status;
  assign out_fire_reset    = result_r.fire_reset;
  assign out_boot_intent   = result_r.boot_intent;
  assign out_reset_pending = result_r.reset_pending;
  assign out_mode_now      = result_r.mode_now;

endmodule
`default_nettype wire

[hdl/rrh_checker.sv]
`default_nettype none
`include "reset_request_handshake_core_macros.svh"
module rrh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic        out_fire_reset,
  input wire logic [1:0]  out_boot_intent,
  input wire logic        out_reset_pending,
  input wire logic [1:0]  out_mode_now
);

  `RRH_ASSERT_NOW(a_fire_enters_exec, out_valid && out_fire_reset, out_mode_now == rrh_pkg::MODE_RESET_EXEC && out_reset_pending && out_status == rrh_pkg::STATUS_OK)
  `RRH_ASSERT_NOW(a_intent_only_on_fire, out_valid && !out_fire_reset, out_boot_intent == rrh_pkg::INTENT_NONE)
  `RRH_ASSERT_NOW(a_pending_tracks_mode, out_valid, out_reset_pending == (out_mode_now == rrh_pkg::MODE_RESET_WAIT || out_mode_now == rrh_pkg::MODE_RESET_EXEC))
  `RRH_ASSERT_NEXT(a_stalled_result_holds, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_mode_now) && $stable(out_fire_reset))

endmodule

bind reset_request_handshake_core rrh_checker u_rrh_checker (.*);
`default_nettype wire

[bench/tb_reset_request_handshake_core.sv]
`timescale 1ns / 100ps
module tb_reset_request_handshake_core;
  import rrh_pkg::*;

  localparam logic [2:0] ACT_BAD_TOP = 3'd7;
  localparam int OPENING_ROWS = 14;
  localparam int PHASE_ITEMS = 185;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [2:0]  in_action;
  logic [31:0] in_token;
  logic [31:0] in_sequence_number;
  logic [31:0] in_now_ms;
  logic        in_link_drained;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_fire_reset;
  logic [1:0]  out_boot_intent;
  logic        out_reset_pending;
  logic [1:0]  out_mode_now;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  reset_request_handshake_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_action          (in_action),
    .in_token           (in_token),
    .in_sequence_number (in_sequence_number),
    .in_now_ms          (in_now_ms),
    .in_link_drained    (in_link_drained),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_fire_reset     (out_fire_reset),
    .out_boot_intent    (out_boot_intent),
    .out_reset_pending  (out_reset_pending),
    .out_mode_now       (out_mode_now),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  typedef struct {
    mode_t       mode;
    logic [31:0] req_stamp;
    logic [31:0] want_sn;
    logic        reply_seen;
    logic [31:0] reply_stamp;
    logic        button_latched;
  } guard_state_t;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } probe_row_t;

  guard_state_t hs;
  cfg_t         live_cfg;
  result_t      outcome_q[$];
  result_t      oldest_outcome;
  probe_row_t   probes[$];
  int           mismatches;
  int           items_sent;
  bit           quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Handshake state after one item, plus the result it produces.
  function automatic result_t advance_handshake(item_t it);
    result_t     r;
    logic [31:0] need_tok;
    logic [31:0] since_req;
    logic [31:0] since_reply;
    r = '0;
    since_req = it.now_ms - hs.req_stamp;
    since_reply = it.now_ms - hs.reply_stamp;
    case (op_t'(it.opcode))
      OP_CONTROL: begin
        need_tok = (it.action == ACT_REQUEST || it.action == ACT_CONFIRM) ?
                   live_cfg.confirm_token : '0;
        if (it.action > ACT_DISCONNECT || it.token != need_tok) begin
          r.status = STATUS_BAD_ARG;
        end else begin
          case (act_t'(it.action))
            ACT_REQUEST: begin
              if (hs.mode == MODE_RESET_WAIT || hs.mode == MODE_RESET_EXEC) begin
                r.status = STATUS_BAD_STATE;
              end else begin
                hs.req_stamp = it.now_ms;
                hs.mode = MODE_WAIT_CONFIRM;
              end
            end
            ACT_CONFIRM: begin
              if (hs.mode != MODE_WAIT_CONFIRM || since_req > live_cfg.confirm_window_ms) begin
                r.status = STATUS_BAD_STATE;
              end else begin
                hs.want_sn = it.sequence_number;
                hs.reply_seen = 1'b0;
                hs.mode = MODE_RESET_WAIT;
              end
            end
            ACT_DISCONNECT: begin
              if (!hs.button_latched && hs.mode != MODE_RESET_EXEC) begin
                hs.mode = MODE_NORMAL;
                hs.reply_seen = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      OP_REPLY_SENT: begin
        if (hs.mode == MODE_RESET_WAIT && it.sequence_number == hs.want_sn) begin
          hs.reply_stamp = it.now_ms;
          hs.reply_seen = 1'b1;
        end
      end
      OP_TICK: begin
        if (it.link_drained && hs.reply_seen && since_reply >= live_cfg.reply_hold_ms &&
            hs.mode == MODE_RESET_WAIT) begin
          hs.mode = MODE_RESET_EXEC;
          r.fire_reset = 1'b1;
          r.boot_intent = hs.button_latched ? INTENT_LOCAL : INTENT_CONFIRM;
        end
      end
      default: begin
        if (!hs.button_latched) begin
          hs.button_latched = 1'b1;
          hs.reply_stamp = it.now_ms;
          hs.reply_seen = 1'b1;
          hs.mode = MODE_RESET_WAIT;
        end
      end
    endcase
    r.reset_pending = (hs.mode == MODE_RESET_WAIT || hs.mode == MODE_RESET_EXEC);
    r.mode_now = hs.mode;
    return r;
  endfunction

  // Firing is terminal, so random traffic must not fire: drop link_drained if it would.
  function automatic item_t hold_off_firing(item_t it);
    guard_state_t saved;
    result_t      r;
    item_t        o;
    saved = hs;
    r = advance_handshake(it);
    hs = saved;
    o = it;
    if (r.fire_reset) o.link_drained = 1'b0;
    return o;
  endfunction

  function automatic item_t mk_item(logic [1:0] op, logic [2:0] act, logic [31:0] tok,
                                    logic [31:0] sn, logic [31:0] now, logic drained);
    item_t it;
    it.opcode = op;
    it.action = act;
    it.token = tok;
    it.sequence_number = sn;
    it.now_ms = now;
    it.link_drained = drained;
    return it;
  endfunction

  function automatic result_t mk_res(logic [1:0] st, logic fire, logic [1:0] intent,
                                     logic pend, logic [1:0] md);
    result_t r;
    r.status = st;
    r.fire_reset = fire;
    r.boot_intent = intent;
    r.reset_pending = pend;
    r.mode_now = md;
    return r;
  endfunction

  function automatic void add_probe(item_t s, bit typed, result_t w);
    probe_row_t p;
    p.stim = s;
    p.typed = typed;
    p.want = w;
    probes.push_back(p);
  endfunction

  function automatic logic [31:0] pick_token();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return live_cfg.confirm_token;
      2: return $urandom;
      default: return live_cfg.confirm_token ^ (32'h1 << $urandom_range(0, 31));
    endcase
  endfunction

  // Times at base + span or either side of it, where the window and hold compares flip, or near base, or random.
  function automatic logic [31:0] near_edge(logic [31:0] base, logic [31:0] span);
    case ($urandom_range(0, 4))
      0: return base + span - 32'd1;
      1: return base + span;
      2: return base + span + 32'd1;
      3: return base + $urandom_range(0, 50);
      default: return $urandom;
    endcase
  endfunction

  function automatic void load_probes();
    // opening rows, reset configuration
    add_probe(mk_item(OP_TICK, ACT_PING, '0, '0, '0, 1'b1), 1'b1,
              mk_res(STATUS_OK, 1'b0, INTENT_NONE, 1'b0, MODE_NORMAL));
    add_probe(mk_item(OP_CONTROL, ACT_BAD_TOP, '0, '0, '0, 1'b0), 1'b1,
              mk_res(STATUS_BAD_ARG, 1'b0, INTENT_NONE, 1'b0, MODE_NORMAL));
    add_probe(mk_item(OP_CONTROL, ACT_PING, 32'hFFFF_FFFF, '0, '0, 1'b0), 1'b1,
              mk_res(STATUS_BAD_ARG, 1'b0, INTENT_NONE, 1'b0, MODE_NORMAL));
    add_probe(mk_item(OP_CONTROL, ACT_PING, '0, '0, '0, 1'b0), 1'b1,
              mk_res(STATUS_OK, 1'b0, INTENT_NONE, 1'b0, MODE_NORMAL));
    add_probe(mk_item(OP_CONTROL, ACT_CONFIRM, '0, '0, '0, 1'b0), 1'b1,
              mk_res(STATUS_BAD_STATE, 1'b0, INTENT_NONE, 1'b0, MODE_NORMAL));
    add_probe(mk_item(OP_REPLY_SENT, ACT_PING, '0, '0, '0, 1'b0), 1'b1,
              mk_res(STATUS_OK, 1'b0, INTENT_NONE, 1'b0, MODE_NORMAL));
    add_probe(mk_item(OP_CONTROL, ACT_REQUEST, '0, '0, 32'hFFFF_FFF0, 1'b0), 1'b1,
              mk_res(STATUS_OK, 1'b0, INTENT_NONE, 1'b0, MODE_WAIT_CONFIRM));
    // one past the window, across the wrap
    add_probe(mk_item(OP_CONTROL, ACT_CONFIRM, '0, 32'd1, 32'h0000_7521, 1'b0), 1'b1,
              mk_res(STATUS_BAD_STATE, 1'b0, INTENT_NONE, 1'b0, MODE_WAIT_CONFIRM));
    add_probe(mk_item(OP_CONTROL, ACT_CONFIRM, '0, 32'hFFFF_FFFF, 32'h0000_7520, 1'b1),
              1'b0, '0);
    add_probe(mk_item(OP_CONTROL, ACT_REQUEST, '0, '0, 32'd10, 1'b0), 1'b1,
              mk_res(STATUS_BAD_STATE, 1'b0, INTENT_NONE, 1'b1, MODE_RESET_WAIT));
    add_probe(mk_item(OP_REPLY_SENT, ACT_PING, '0, '0, 32'd7, 1'b1), 1'b0, '0);
    add_probe(mk_item(OP_REPLY_SENT, ACT_PING, '0, 32'hFFFF_FFFF, '0, 1'b0), 1'b0, '0);
    add_probe(mk_item(OP_TICK, ACT_PING, '0, '0, 32'hFFFF_FFFF, 1'b0), 1'b0, '0);
    add_probe(mk_item(OP_CONTROL, ACT_DISCONNECT, '0, '0, '0, 1'b0), 1'b1,
              mk_res(STATUS_OK, 1'b0, INTENT_NONE, 1'b0, MODE_NORMAL));
    // closing rows: firing, ticks after firing, local button
    add_probe(mk_item(OP_CONTROL, ACT_DISCONNECT, '0, '0, '0, 1'b1), 1'b1,
              mk_res(STATUS_OK, 1'b0, INTENT_NONE, 1'b0, MODE_NORMAL));
    add_probe(mk_item(OP_CONTROL, ACT_REQUEST, '0, '0, 32'd100, 1'b0), 1'b0, '0);
    add_probe(mk_item(OP_CONTROL, ACT_CONFIRM, '0, 32'h5A5A_5A5A, 32'd200, 1'b0), 1'b0, '0);
    add_probe(mk_item(OP_REPLY_SENT, ACT_PING, '0, 32'h5A5A_5A5A, 32'd1000, 1'b0), 1'b0, '0);
    add_probe(mk_item(OP_TICK, ACT_PING, '0, '0, 32'd2499, 1'b1), 1'b0, '0);
    add_probe(mk_item(OP_TICK, ACT_PING, '0, '0, 32'd2500, 1'b1), 1'b1,
              mk_res(STATUS_OK, 1'b1, INTENT_CONFIRM, 1'b1, MODE_RESET_EXEC));
    add_probe(mk_item(OP_TICK, ACT_PING, '0, '0, 32'd2500, 1'b1), 1'b1,
              mk_res(STATUS_OK, 1'b0, INTENT_NONE, 1'b1, MODE_RESET_EXEC));
    add_probe(mk_item(OP_CONTROL, ACT_DISCONNECT, '0, '0, '0, 1'b0), 1'b1,
              mk_res(STATUS_OK, 1'b0, INTENT_NONE, 1'b1, MODE_RESET_EXEC));
    add_probe(mk_item(OP_CONTROL, ACT_REQUEST, '0, '0, '0, 1'b0), 1'b1,
              mk_res(STATUS_BAD_STATE, 1'b0, INTENT_NONE, 1'b1, MODE_RESET_EXEC));
    add_probe(mk_item(OP_BUTTON, ACT_PING, '0, '0, 32'hFFFF_FFFF, 1'b0), 1'b1,
              mk_res(STATUS_OK, 1'b0, INTENT_NONE, 1'b1, MODE_RESET_WAIT));
    add_probe(mk_item(OP_BUTTON, ACT_PING, '0, '0, 32'd5, 1'b1), 1'b1,
              mk_res(STATUS_OK, 1'b0, INTENT_NONE, 1'b1, MODE_RESET_WAIT));
    add_probe(mk_item(OP_CONTROL, ACT_DISCONNECT, '0, '0, '0, 1'b0), 1'b1,
              mk_res(STATUS_OK, 1'b0, INTENT_NONE, 1'b1, MODE_RESET_WAIT));
    add_probe(mk_item(OP_TICK, ACT_PING, '0, '0, 32'h0000_05DA, 1'b1), 1'b0, '0);
    add_probe(mk_item(OP_TICK, ACT_PING, '0, '0, 32'h0000_05DB, 1'b1), 1'b1,
              mk_res(STATUS_OK, 1'b1, INTENT_LOCAL, 1'b1, MODE_RESET_EXEC));
  endfunction

  // Entered and left on a falling edge; in_valid stays high after the transfer.
  task automatic send_item(item_t it, bit typed, result_t typed_res);
    int      gap;
    result_t r;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode = it.opcode;
    in_action = it.action;
    in_token = it.token;
    in_sequence_number = it.sequence_number;
    in_now_ms = it.now_ms;
    in_link_drained = it.link_drained;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    r = advance_handshake(it);
    outcome_q.push_back(typed ? typed_res : r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_setting(logic [1:0] idx, logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CONFIRM_TOKEN: live_cfg.confirm_token = val;
      CFG_WINDOW_MS:     live_cfg.confirm_window_ms = val;
      CFG_HOLD_MS:       live_cfg.reply_hold_ms = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(logic [31:0] tok, logic [31:0] win, logic [31:0] hold);
    write_setting(CFG_CONFIRM_TOKEN, tok);
    write_setting(CFG_WINDOW_MS, win);
    write_setting(CFG_HOLD_MS, hold);
    cfg_valid = 1'b0;
  endtask

  task automatic send_noise();
    item_t it;
    it = mk_item(2'($urandom_range(OP_CONTROL, OP_TICK)),
                 3'($urandom_range(ACT_PING, ACT_BAD_TOP)),
                 pick_token(), $urandom, $urandom, 1'($urandom_range(0, 1)));
    send_item(hold_off_firing(it), 1'b0, '0);
  endtask

  // Request, confirm, then a mix of replies, ticks, pings and noise items, then disconnect.
  task automatic run_episode();
    item_t       it;
    logic [31:0] tok;
    int          steps;
    tok = ($urandom_range(0, 7) == 0) ? pick_token() : live_cfg.confirm_token;
    it = mk_item(OP_CONTROL, ACT_REQUEST, tok, $urandom, $urandom, 1'($urandom_range(0, 1)));
    send_item(it, 1'b0, '0);
    tok = ($urandom_range(0, 7) == 0) ? pick_token() : live_cfg.confirm_token;
    it = mk_item(OP_CONTROL, ACT_CONFIRM, tok, $urandom,
                 near_edge(hs.req_stamp, live_cfg.confirm_window_ms),
                 1'($urandom_range(0, 1)));
    send_item(it, 1'b0, '0);
    steps = $urandom_range(1, 8);
    repeat (steps) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          it = mk_item(OP_REPLY_SENT, 3'($urandom_range(ACT_PING, ACT_BAD_TOP)), $urandom,
                       ($urandom_range(0, 3) != 0) ? hs.want_sn : $urandom, $urandom,
                       1'($urandom_range(0, 1)));
          send_item(it, 1'b0, '0);
        end
        2, 3: begin
          it = mk_item(OP_TICK, 3'($urandom_range(ACT_PING, ACT_BAD_TOP)), $urandom,
                       $urandom, near_edge(hs.reply_stamp, live_cfg.reply_hold_ms),
                       1'($urandom_range(0, 1)));
          send_item(hold_off_firing(it), 1'b0, '0);
        end
        4: begin
          it = mk_item(OP_CONTROL, ACT_PING, $urandom_range(0, 1) ? '0 : pick_token(),
                       $urandom, $urandom, 1'($urandom_range(0, 1)));
          send_item(it, 1'b0, '0);
        end
        default: send_noise();
      endcase
    end
    it = mk_item(OP_CONTROL, ACT_DISCONNECT, ($urandom_range(0, 4) != 0) ? '0 : pick_token(),
                 $urandom, $urandom, 1'($urandom_range(0, 1)));
    send_item(it, 1'b0, '0);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        $error("result transfer with no outcome pending");
        mismatches++;
      end else begin
        oldest_outcome = outcome_q.pop_front();
        check_field("status", 32'(oldest_outcome.status), 32'(out_status));
        check_field("fire_reset", 32'(oldest_outcome.fire_reset), 32'(out_fire_reset));
        check_field("boot_intent", 32'(oldest_outcome.boot_intent), 32'(out_boot_intent));
        check_field("reset_pending", 32'(oldest_outcome.reset_pending),
                    32'(out_reset_pending));
        check_field("mode_now", 32'(oldest_outcome.mode_now), 32'(out_mode_now));
      end
    end
  end

  initial begin
    int hold_cycles;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      hold_cycles = quiet ? 0 : $urandom_range(0, 11);
      if (hold_cycles != 0) begin
        out_stall = 1'b1;
        repeat (hold_cycles) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    int guard;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_CONTROL;
    in_action = ACT_PING;
    in_token = '0;
    in_sequence_number = '0;
    in_now_ms = '0;
    in_link_drained = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CONFIRM_TOKEN;
    cfg_data = '0;
    mismatches = 0;
    items_sent = 0;
    quiet = 1'b0;
    hs = '{MODE_NORMAL, '0, '0, 1'b0, '0, 1'b0};
    live_cfg = '{TOKEN_RESET, WINDOW_RESET, HOLD_RESET};
    load_probes();

    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < OPENING_ROWS; i++) send_item(probes[i].stim, probes[i].typed, probes[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: apply_settings($urandom, $urandom_range(0, 2000), $urandom_range(0, 3000));
        1: apply_settings(32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
        2: apply_settings('0, 32'hFFFF_FFFF, '0);
        3: apply_settings($urandom, WINDOW_RESET, HOLD_RESET);
        default: apply_settings($urandom, $urandom, $urandom);
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      while (items_sent < OPENING_ROWS + (ph + 1) * PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) quiet = !quiet;
        if ($urandom_range(0, 4) == 0) send_noise();
        else run_episode();
        // drain everything now and then
        if ($urandom_range(0, 29) == 0) settle();
      end
    end

    settle();
    apply_settings(TOKEN_RESET, WINDOW_RESET, HOLD_RESET);
    for (int i = OPENING_ROWS; i < probes.size(); i++) begin
      send_item(probes[i].stim, probes[i].typed, probes[i].want);
    end

    in_valid = 1'b0;
    for (guard = 0; guard < 5000 && outcome_q.size() != 0; guard++) @(negedge clk);
    repeat (6) @(negedge clk);
    if (outcome_q.size() != 0) begin
      $error("%0d outcomes never arrived", outcome_q.size());
      mismatches++;
    end
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
